[rtl/pirms_pkg.sv]
// Package for the positional insert / range minimum store.
// Holds field widths, opcodes, status codes and defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pirms_pkg;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam int POS_W   = 11;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  localparam logic signed [VALUE_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

endpackage

`default_nettype wire

[rtl/pirms_if.sv]
// Valid/ready channel interfaces for items and results.
// Depends on pirms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pirms_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [pirms_pkg::POS_W-1:0]         insert_position;
  logic signed [pirms_pkg::VALUE_W-1:0] value;
  logic [pirms_pkg::INDEX_W-1:0]       first_index;
  logic [pirms_pkg::INDEX_W-1:0]       last_index;

  modport source (output valid, opcode, insert_position, value, first_index, last_index,
                  input ready);
  modport sink (input valid, opcode, insert_position, value, first_index, last_index,
                output ready);
endinterface

interface pirms_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pirms_pkg::VALUE_W-1:0] range_min;
  logic [pirms_pkg::STATUS_W-1:0]       status;

  modport source (output valid, range_min, status, input ready);
  modport sink (input valid, range_min, status, output ready);
endinterface

`default_nettype wire

[rtl/pirms_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pirms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/positional_insert_range_min_store_core.sv]
// Top level of the positional insert / range minimum store.
// Depends on pirms_pkg, the channel interfaces in pirms_if and pirms_ram.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps an ordered sequence of up to CAPACITY signed 32-bit values
// in a single RAM with one write and one registered read port. An insert
// transfer places its value so that exactly insert_position elements stay
// before it (a position past the end appends); a query transfer returns the
// minimum over the inclusive index range, clipped to the stored length, or
// 2147483647 when that range is empty. Every item produces exactly one result
// transfer. Items are handled one at a time by a small sequencer around the
// RAM port and a single 32-bit compare: an insert reads each later element and
// writes it back one slot higher, at one element per cycle, before the new
// value goes into the gap, and an append writes its value directly. A query
// makes one RAM read per element in its clipped range, and an empty query or a
// refused insert into a full store goes straight to its result. The result is
// loaded into an output register and sits there, so the block returns to
// accepting items as soon as the result is loaded, even while it waits to be
// taken; only when an earlier result is still waiting does the last step of an
// item hold until that result leaves. The block is not ready while reset is
// asserted.
// No clearing pass is needed after reset: only entries below the element
// count are ever read.
module positional_insert_range_min_store_core #(
  parameter int CAPACITY = pirms_pkg::CAPACITY_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst,
  pirms_in_if.sink     item_in,
  pirms_out_if.source  result_out
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // Common width for comparing port indexes against the element count.
  localparam int PW = (CW > pirms_pkg::POS_W) ? CW : pirms_pkg::POS_W;

  typedef enum logic [2:0] {
    IDLE,
    SHIFT,
    SHIFT_DRAIN,
    PUT,
    SCAN,
    SCAN_DRAIN,
    FINISH
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic [AW-1:0] addr;
  logic [AW-1:0] pend_addr;
  logic          pend;
  logic [AW-1:0] pos;
  logic [AW-1:0] hi;
  logic signed [pirms_pkg::VALUE_W-1:0] val;
  logic signed [pirms_pkg::VALUE_W-1:0] best;
  logic signed [pirms_pkg::VALUE_W-1:0] res_min;
  logic [pirms_pkg::STATUS_W-1:0]       res_status;

  logic                                 out_valid;
  logic signed [pirms_pkg::VALUE_W-1:0] out_min;
  logic [pirms_pkg::STATUS_W-1:0]       out_status;

  // RAM port signals.
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [pirms_pkg::VALUE_W-1:0] ram_wdata;
  logic [pirms_pkg::VALUE_W-1:0] ram_rdata;
  logic signed [pirms_pkg::VALUE_W-1:0] rd_value;

  // Index arithmetic on the incoming item, all at the common width.
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] cnt_m1;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] first_ext;
  logic [PW-1:0] last_ext;
  logic [PW-1:0] hi_ext;
  logic          store_full;
  logic          append;
  logic          range_empty;
  logic          new_is_lower;

  assign cnt_ext   = PW'(count);
  assign cnt_m1    = cnt_ext - PW'(1);
  assign pos_ext   = PW'(item_in.insert_position);
  assign first_ext = PW'(item_in.first_index);
  assign last_ext  = PW'(item_in.last_index);
  assign hi_ext    = (last_ext >= cnt_ext) ? cnt_m1 : last_ext;

  assign store_full  = (cnt_ext >= PW'(CAPACITY));
  assign append      = (pos_ext >= cnt_ext);
  // A reversed range, or one that starts at or past the end, has no elements;
  // this also covers the empty store.
  assign range_empty = (item_in.first_index > item_in.last_index) ||
                       (first_ext >= cnt_ext);

  // The shared compare: the element just read against the running minimum.
  assign rd_value     = $signed(ram_rdata);
  assign new_is_lower = (rd_value < best);

  assign item_in.ready        = !rst && (state == IDLE);
  assign result_out.valid     = out_valid;
  assign result_out.range_min = out_min;
  assign result_out.status    = out_status;

  pirms_ram #(
    .WIDTH(pirms_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Write side: during a shift, the element read in the previous cycle lands
  // one slot higher; the new value is written once the gap is open.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr + AW'(1);
    ram_wdata = ram_rdata;
    case (state)
      SHIFT, SHIFT_DRAIN: begin
        ram_we = pend;
      end
      PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = val;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A result taken while the next one is loaded is handled in FINISH.
      if (out_valid && result_out.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          pend <= 1'b0;
          if (item_in.valid) begin
            val <= item_in.value;
            if (item_in.opcode == pirms_pkg::OP_INSERT) begin
              if (store_full) begin
                res_min    <= '0;
                res_status <= pirms_pkg::STATUS_FULL;
                state      <= FINISH;
              end else if (append) begin
                pos   <= cnt_ext[AW-1:0];
                state <= PUT;
              end else begin
                // Walk from the last element down to the insert position.
                pos   <= pos_ext[AW-1:0];
                addr  <= cnt_m1[AW-1:0];
                state <= SHIFT;
              end
            end else begin
              best       <= pirms_pkg::EMPTY_MIN;
              res_status <= pirms_pkg::STATUS_ANSWERED;
              if (range_empty) begin
                res_min <= pirms_pkg::EMPTY_MIN;
                state   <= FINISH;
              end else begin
                addr  <= first_ext[AW-1:0];
                hi    <= hi_ext[AW-1:0];
                state <= SCAN;
              end
            end
          end
        end
        SHIFT: begin
          pend      <= 1'b1;
          pend_addr <= addr;
          if (addr == pos) begin
            state <= SHIFT_DRAIN;
          end else begin
            addr <= addr - AW'(1);
          end
        end
        SHIFT_DRAIN: begin
          pend  <= 1'b0;
          state <= PUT;
        end
        PUT: begin
          count      <= count + CW'(1);
          res_min    <= '0;
          res_status <= pirms_pkg::STATUS_INSERTED;
          state      <= FINISH;
        end
        SCAN: begin
          pend <= 1'b1;
          if (pend && new_is_lower) begin
            best <= rd_value;
          end
          if (addr == hi) begin
            state <= SCAN_DRAIN;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        SCAN_DRAIN: begin
          // The last element of the range is on the read port now.
          pend    <= 1'b0;
          res_min <= new_is_lower ? rd_value : best;
          state   <= FINISH;
        end
        FINISH: begin
          if (!out_valid || result_out.ready) begin
            out_valid  <= 1'b1;
            out_min    <= res_min;
            out_status <= res_status;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for positional_insert_range_min_store_core.
// Depends on pirms_pkg and the channel interfaces in pirms_if, both from the RTL.
`timescale 1ns / 1ps

// The testbench drives a stream of insert and range minimum query transfers into
// the block and checks every result transfer against a behavioral mirror of the
// ordered store. The mirror is updated in the cycle in which an item transfer is
// accepted. Its prediction is queued there and compared field by field with
// the oldest entry when the next result transfer is taken.
module testbench;

  localparam int POS_W        = pirms_pkg::POS_W;
  localparam int INDEX_W      = pirms_pkg::INDEX_W;
  localparam int VALUE_W      = pirms_pkg::VALUE_W;
  localparam int STATUS_W     = pirms_pkg::STATUS_W;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  localparam int CAPACITY     = pirms_pkg::CAPACITY_DEFAULT;
  localparam int MAX_POSITION = 1024;
  localparam int MAX_INDEX    = 1023;
  // The slowest item is a query over a full store, one RAM read per element.
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                 opcode;
    logic [POS_W-1:0]     insert_position;
    logic [VALUE_W-1:0]   value;
    logic [INDEX_W-1:0]   first_index;
    logic [INDEX_W-1:0]   last_index;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  range_min;
    logic [STATUS_W-1:0] status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pirms_in_if  item_if ();
  pirms_out_if result_if ();

  positional_insert_range_min_store_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if)
  );

  // Mirror of the ordered store: only entries below mirror_count are meaningful.
  logic signed [VALUE_W-1:0] mirror_values [0:CAPACITY-1];
  int unsigned               mirror_count = 0;

  // Predicted results, oldest first.
  result_t pending_results [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  logic hold_results  = 1'b0;

  always #CLK_HALF clk = ~clk;

  // Every input of the block is known from time zero.
  initial begin
    item_if.valid           = 1'b0;
    item_if.opcode          = pirms_pkg::OP_INSERT;
    item_if.insert_position = '0;
    item_if.value           = '0;
    item_if.first_index     = '0;
    item_if.last_index      = '0;
    result_if.ready         = 1'b0;
  end

  // Applies one item to the mirror and returns the result the block must give.
  // An insert clamps its position to the current length and shifts the tail up,
  // or is refused when the store is full; a query clips the range to the stored
  // length and falls back to the largest positive value when nothing is left.
  function automatic result_t insert_or_scan(input item_t it);
    result_t                   r;
    int unsigned               pos;
    int unsigned               lo;
    int unsigned               hi;
    logic signed [VALUE_W-1:0] best;
    r.range_min = '0;
    if (it.opcode == pirms_pkg::OP_INSERT) begin
      if (mirror_count >= CAPACITY) begin
        r.status = pirms_pkg::STATUS_FULL;
      end else begin
        pos = it.insert_position;
        if (pos > mirror_count) pos = mirror_count;
        for (int i = mirror_count; i > pos; i--) mirror_values[i] = mirror_values[i-1];
        mirror_values[pos] = it.value;
        mirror_count++;
        r.status = pirms_pkg::STATUS_INSERTED;
      end
    end else begin
      best = VALUE_MAX;
      lo = it.first_index;
      hi = it.last_index;
      if (mirror_count > 0 && lo <= hi && lo < mirror_count) begin
        if (hi >= mirror_count) hi = mirror_count - 1;
        for (int i = lo; i <= hi; i++)
          if (mirror_values[i] < best) best = mirror_values[i];
      end
      r.range_min = best;
      r.status    = pirms_pkg::STATUS_ANSWERED;
    end
    return r;
  endfunction

  // The fields an operation ignores still carry random bits.
  function automatic item_t insert_item(input int pos, input logic [VALUE_W-1:0] v);
    item_t it;
    it.opcode          = pirms_pkg::OP_INSERT;
    it.insert_position = POS_W'(pos);
    it.value           = v;
    it.first_index     = INDEX_W'($urandom);
    it.last_index      = INDEX_W'($urandom);
    return it;
  endfunction

  function automatic item_t query_item(input int first, input int last);
    item_t it;
    it.opcode          = pirms_pkg::OP_QUERY;
    it.insert_position = POS_W'($urandom_range(0, MAX_POSITION));
    it.value           = $urandom;
    it.first_index     = INDEX_W'(first);
    it.last_index      = INDEX_W'(last);
    return it;
  endfunction

  // Values lean toward the extremes and toward a narrow band, so ties and
  // sign boundaries show up often in the minimum.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2, 3:    return VALUE_W'(int'($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t random_insert();
    int pos;
    case ($urandom_range(0, 9))
      0, 1:    pos = 0;
      2, 3:    pos = mirror_count;
      4:       pos = $urandom_range(mirror_count, MAX_POSITION);
      default: pos = $urandom_range(0, mirror_count);
    endcase
    return insert_item(pos, random_value());
  endfunction

  function automatic item_t random_query();
    int top;
    int lo;
    int hi;
    top = (mirror_count == 0) ? 0 : mirror_count - 1;
    case ($urandom_range(0, 9))
      0: begin
        // Reversed range.
        hi = $urandom_range(0, MAX_INDEX - 1);
        lo = $urandom_range(hi + 1, MAX_INDEX);
      end
      1: begin
        lo = $urandom_range(0, MAX_INDEX);
        hi = $urandom_range(0, MAX_INDEX);
      end
      2: begin
        // Range that runs past the end of the store.
        lo = $urandom_range(0, top);
        hi = $urandom_range(top, MAX_INDEX);
      end
      3: begin
        lo = $urandom_range(0, top);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(0, top);
        hi = $urandom_range(lo, top);
      end
    endcase
    return query_item(lo, hi);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Offers one item, with random idle cycles first, and returns after the edge
  // at which it is accepted. Valid is left high so that a following item can
  // go out back to back; whoever waits afterwards lowers it.
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid           <= 1'b1;
    item_if.opcode          <= it.opcode;
    item_if.insert_position <= it.insert_position;
    item_if.value           <= it.value;
    item_if.first_index     <= it.first_index;
    item_if.last_index      <= it.last_index;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    pending_results.push_back(insert_or_scan(it));
  endtask

  // The receiver stalls at random, and throughout a long hold-off.
  always @(posedge clk) begin
    if (rst || hold_results) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result (min %0d, status %0d) with nothing outstanding",
                                  $signed(result_if.range_min), result_if.status));
      end else begin
        want = pending_results.pop_front();
        if (result_if.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result_if.status, want.status));
        if (result_if.range_min !== want.range_min)
          report_mismatch($sformatf("range_min %0d, expected %0d",
                                    $signed(result_if.range_min), $signed(want.range_min)));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_insert_range_min_store_core regression: fail");
      $finish;
    end
  end

  // Queries on an empty store all come back empty; then the first inserts
  // cover an append past the end, a front insert and both value extremes.
  // The store ends up as MAX, 0, MIN, -1.
  task automatic test_empty_store();
    send_item(query_item(0, 0));
    send_item(query_item(0, MAX_INDEX));
    send_item(query_item(MAX_INDEX, MAX_INDEX));
    send_item(query_item(7, 2));
    send_item(insert_item(MAX_POSITION, VALUE_MIN));
    send_item(insert_item(0, VALUE_MAX));
    send_item(insert_item(1, '0));
    send_item(insert_item(3, 32'hFFFF_FFFF));
  endtask

  // Inserts in the middle, exactly at the end, one past the end and at
  // position MAX_POSITION, well past the end.
  task automatic test_insert_positions();
    send_item(insert_item(2, 32'd5));
    send_item(insert_item(mirror_count, 32'h4000_0000));
    send_item(insert_item(mirror_count + 1, random_value()));
    send_item(insert_item(1, VALUE_MIN));
    send_item(insert_item(MAX_POSITION, VALUE_MAX));
  endtask

  // Ranges that are full, clipped, single, reversed and wholly past the end.
  task automatic test_query_ranges();
    send_item(query_item(0, MAX_INDEX));
    send_item(query_item(0, mirror_count - 1));
    send_item(query_item(mirror_count - 1, mirror_count - 1));
    send_item(query_item(mirror_count, MAX_INDEX));
    send_item(query_item(MAX_INDEX, MAX_INDEX));
    send_item(query_item(4, 2));
    send_item(query_item(1, 1));
    send_item(query_item(2, mirror_count));
    send_item(query_item(3, 3));
  endtask

  // Mixed traffic, slightly more inserts than queries so the store keeps
  // growing and later queries scan longer ranges.
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    recv_idle_pct  <= recv_pct;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55) send_item(random_insert());
      else send_item(random_query());
    end
  endtask

  // The receiver holds off for a long stretch while cheap items keep coming,
  // so the output register fills and the block must stall its input.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end
      begin
        repeat (16) begin
          if ($urandom_range(0, 1) == 0) send_item(insert_item(mirror_count, random_value()));
          else send_item(query_item(9, 3));
        end
        item_if.valid <= 1'b0;
      end
    join
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 26;
    recv_idle_pct  <= 45;
    test_empty_store();
    test_insert_positions();
    test_query_ranges();

    // Idling pattern: receiver-heavy stalls, then sender-heavy, then none.
    test_random_traffic(180, 26, 45);
    test_random_traffic(180, 45, 26);
    test_random_traffic(180, 0, 0);

    test_backpressure();

    // Let every outstanding result arrive, then watch a while for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("positional_insert_range_min_store_core regression: pass");
    end else begin
      $display("positional_insert_range_min_store_core regression: fail");
    end
    $finish;
  end

endmodule
